// ===== rtl/core/ffs_pkg.sv =====
// Package for the framed field splitter: word types, character codes,
// front/back command type and default sizes. No dependencies.
`timescale 1ns / 1ps

package ffs_pkg;

  localparam int MAX_FIELDS_DEF = 20;
  localparam int FIELD_LEN_DEF  = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_OPEN   = 8'h3C;
  localparam logic [7:0] CH_CLOSE  = 8'h3E;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] SEP_RESET = 8'h3B;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  typedef enum logic [1:0] {
    PH_AWAIT,
    PH_BODY,
    PH_BAD
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [4:0] field_index;
    logic [3:0] char_position;
    logic [7:0] char_value;
    logic       frame_ok;
    logic [4:0] field_total;
    logic       last_result;
  } out_word_t;

  // Up to three results per input byte: a body character or separator end,
  // the closing field end, and the frame result.
  typedef struct packed {
    logic       a_vld;
    logic       a_end;
    logic [4:0] a_fidx;
    logic [3:0] a_pos;
    logic [7:0] a_ch;
    logic       b_vld;
    logic [4:0] b_fidx;
    logic [3:0] b_pos;
    logic       c_vld;
    logic       c_ok;
    logic [4:0] c_total;
  } cmd_t;

endpackage

// ===== rtl/core/ffs_front.sv =====
// Front end: framing state machine, one-byte hold and field counters.
// Turns each accepted word into a command for the back end. Uses ffs_pkg.
`timescale 1ns / 1ps

module ffs_front import ffs_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF,
  parameter int FIELD_LEN  = FIELD_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_word_t   in_word,
  input  logic [7:0] sep_char,
  output logic       push,
  output cmd_t       cmd
);

  localparam int FW = $clog2(MAX_FIELDS + 1);
  localparam int PW = (FIELD_LEN > 2) ? $clog2(FIELD_LEN) : 1;

  phase_t        phase_r, phase_nxt;
  logic [7:0]    held_r, held_nxt;
  logic          held_vld_r, held_vld_nxt;
  logic [FW-1:0] field_r, field_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  logic       crlf, body_seen, ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_AWAIT;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      field_r    <= '0;
      pos_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      field_r    <= field_nxt;
      pos_r      <= pos_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    field_nxt    = field_r;
    pos_nxt      = pos_r;
    cmd          = '0;
    crlf         = (in_word.data_byte == CH_CR) || (in_word.data_byte == CH_LF);
    body_seen    = 1'b0;
    ok           = 1'b0;

    if (accept && !crlf) begin
      case (phase_r)
        PH_AWAIT: begin
          phase_nxt = (in_word.data_byte == CH_OPEN) ? PH_BODY : PH_BAD;
        end
        PH_BODY: begin
          if (held_vld_r && (field_r < FW'(MAX_FIELDS))) begin
            if (held_r == sep_char) begin
              cmd.a_vld  = 1'b1;
              cmd.a_end  = 1'b1;
              cmd.a_fidx = 5'(field_r);
              cmd.a_pos  = 4'(pos_r);
              field_nxt  = field_r + 1'b1;
              pos_nxt    = '0;
            end else if (pos_r < PW'(FIELD_LEN - 1)) begin
              cmd.a_vld  = 1'b1;
              cmd.a_fidx = 5'(field_r);
              cmd.a_pos  = 4'(pos_r);
              cmd.a_ch   = held_r;
              pos_nxt    = pos_r + 1'b1;
            end
          end
          held_nxt     = in_word.data_byte;
          held_vld_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (accept && in_word.last_byte) begin
      body_seen = (field_nxt != '0) || (pos_nxt != '0);
      ok = (phase_nxt == PH_BODY) && held_vld_nxt && (held_nxt == CH_CLOSE) && body_seen;
      cmd.c_vld = 1'b1;
      cmd.c_ok  = ok;
      if (ok) begin
        if (field_nxt < FW'(MAX_FIELDS)) begin
          cmd.b_vld   = 1'b1;
          cmd.b_fidx  = 5'(field_nxt);
          cmd.b_pos   = 4'(pos_nxt);
          cmd.c_total = 5'(field_nxt + 1'b1);
        end else begin
          cmd.c_total = 5'(field_nxt);
        end
      end
      phase_nxt    = PH_AWAIT;
      held_nxt     = '0;
      held_vld_nxt = 1'b0;
      field_nxt    = '0;
      pos_nxt      = '0;
    end
  end

  assign push = cmd.a_vld || cmd.b_vld || cmd.c_vld;

endmodule

// ===== rtl/core/ffs_queue.sv =====
// Short command queue between front and back ends.
// Register-array FIFO of cmd_t entries. Uses ffs_pkg.
`timescale 1ns / 1ps

module ffs_queue import ffs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rd_ptr_r];

endmodule

// ===== rtl/core/ffs_back.sv =====
// Back end: unpacks one command into its result words, one per cycle while
// the output is not stalled, into the output register. Uses ffs_pkg.
`timescale 1ns / 1ps

module ffs_back import ffs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_vld,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  cmd_t       cmd_r, cmd_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic       out_vld_r, out_vld_nxt;
  out_word_t  out_r, out_nxt;

  logic       issue;
  logic [2:0] sel, rem_after;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      rem_r     <= rem_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    issue     = (rem_r != '0) && (!out_vld_r || out_ready);
    sel       = rem_r & (~rem_r + 3'd1);
    rem_after = issue ? (rem_r & ~sel) : rem_r;
    q_pop     = q_vld && (rem_after == '0);
    rem_nxt   = q_pop ? {q_head.c_vld, q_head.b_vld, q_head.a_vld} : rem_after;
    cmd_nxt   = q_pop ? q_head : cmd_r;

    out_nxt     = out_r;
    out_vld_nxt = out_ready ? 1'b0 : out_vld_r;
    if (issue) begin
      out_vld_nxt = 1'b1;
      out_nxt     = '0;
      if (sel[0]) begin
        out_nxt.result_kind   = cmd_r.a_end ? KIND_END : KIND_CHAR;
        out_nxt.field_index   = cmd_r.a_fidx;
        out_nxt.char_position = cmd_r.a_pos;
        out_nxt.char_value    = cmd_r.a_ch;
      end else if (sel[1]) begin
        out_nxt.result_kind   = KIND_END;
        out_nxt.field_index   = cmd_r.b_fidx;
        out_nxt.char_position = cmd_r.b_pos;
      end else begin
        out_nxt.result_kind = KIND_DONE;
        out_nxt.frame_ok    = cmd_r.c_ok;
        out_nxt.field_total = cmd_r.c_total;
      end
      out_nxt.last_result = ((rem_r & ~sel) == '0);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/framed_field_splitter_top.sv =====
// Top level of the framed field splitter: separator register, front end,
// command queue and back end. Uses ffs_pkg, ffs_front, ffs_queue, ffs_back.
`timescale 1ns / 1ps

// Accepts one message byte per cycle. A byte yields one result or none, but
// the final byte can yield up to three; the back end sends one result word
// per cycle from its output register while out_ready allows. A four-entry
// command queue between the front and back ends absorbs these bursts and
// output stalls; input ready drops only while that queue is full. A result
// passes through the queue, the back end's command register and its output
// register. Write the separator only while the block is idle.

module framed_field_splitter_top import ffs_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF,
  parameter int FIELD_LEN  = FIELD_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] sep_r;
  logic       accept, push, full, q_vld, q_pop;
  cmd_t       cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  ffs_front #(
    .MAX_FIELDS (MAX_FIELDS),
    .FIELD_LEN  (FIELD_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_data),
    .sep_char (sep_r),
    .push     (push),
    .cmd      (cmd)
  );

  ffs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (cmd),
    .pop       (q_pop),
    .full      (full),
    .not_empty (q_vld),
    .head      (q_head)
  );

  ffs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KIND_DONE) |-> out_data.last_result)
    else $error("frame result not marked last");

  a_ok_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind != KIND_DONE) |->
      !out_data.frame_ok && (out_data.field_total == 5'd0))
    else $error("frame status on a field word");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");
`endif

endmodule
